>>> rtl/bfir_pkg.sv
package bfir_pkg;

  // Register sizes and limits
  localparam int unsigned REG_W       = 11;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned SIZE_LIMIT  = 1024;
  localparam int unsigned REG_RESET   = 256;

  localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = 2'd3;

  // Image store
  localparam int unsigned PIX_W       = 32;
  localparam int unsigned IMG_DEPTH   = 65536;
  localparam int unsigned IMG_ADDR_W  = $clog2(IMG_DEPTH);

  // Load index spans the largest source image
  localparam int unsigned LOAD_W      = 20;
  localparam int unsigned TOTAL_W     = LOAD_W + 1;

  // Output coordinates
  localparam int unsigned COORD_W     = 10;

  // Serial divider
  localparam int unsigned DIV_NUM_W   = 27;
  localparam int unsigned DIV_DEN_W   = 13;
  localparam int unsigned DIV_CNT_W   = $clog2(DIV_NUM_W);

  // Fixed-point step
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned STEP_W      = DIV_NUM_W;
  localparam int unsigned BASE_W      = STEP_W + COORD_W;

  // Sample address and per-lane accumulation
  localparam int unsigned SADDR_W     = 22;
  localparam int unsigned LANES       = 4;
  localparam int unsigned LANE_W      = 8;
  localparam int unsigned ACC_W       = LANE_W + 2;

  typedef logic [REG_W-1:0] size_t;

  // Zero acts as one, anything above the limit acts as the limit
  function automatic size_t eff_size(input size_t v);
    size_t r;
    if (v == '0) begin
      r = size_t'(1);
    end else if (v > size_t'(SIZE_LIMIT)) begin
      r = size_t'(SIZE_LIMIT);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

>>> rtl/bfir_ram.sv
module bfir_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/bfir_div.sv
module bfir_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [bfir_pkg::DIV_NUM_W-1:0] num_i,
  input  logic [bfir_pkg::DIV_DEN_W-1:0] den_i,
  output logic                           done_o,
  output logic [bfir_pkg::DIV_NUM_W-1:0] quo_o
);
  import bfir_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_DEN_W-1:0] den_q;
  logic [DIV_DEN_W-1:0] rem_q;
  logic [DIV_NUM_W-1:0] quo_q;
  logic [DIV_DEN_W:0]   rem_shift;
  logic [DIV_DEN_W:0]   rem_diff;
  logic                 qbit;

  // One quotient bit per cycle, restoring
  assign rem_shift = {rem_q, quo_q[DIV_NUM_W-1]};
  assign rem_diff  = rem_shift - {1'b0, den_q};
  assign qbit      = rem_shift >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(DIV_NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= num_i;
    end else if (busy_q) begin
      rem_q <= qbit ? rem_diff[DIV_DEN_W-1:0] : rem_shift[DIV_DEN_W-1:0];
      quo_q <= {quo_q[DIV_NUM_W-2:0], qbit};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

>>> rtl/box_filter_image_resampler_core.sv
// Four-tap box-filter image resampler.
// Input channel (in_valid_i / in_stall_o): mode_i = 0 writes pixel_in_i as the next
// source pixel in raster order, mode_i = 1 requests the next output pixel.
// Output channel (out_valid_o / out_stall_i): one transfer per emit item, carrying
// pixel_out_o and frame_end_o (set on the last pixel of the output image).
// Configuration: cfg_we_i writes cfg_wdata_i to the register at cfg_index_i
// (in width, in height, out width, out height); write only while idle.
// The block stalls input in the cycle after each configuration write.
// Loads stream at one per cycle while the block is idle and not settling after a configuration write.
// An emit item passes through the row check, column, column-sum, four read, accumulate and output states
// to the output register; the four source samples are read one per cycle from the single-port image RAM.
// The first emit after a configuration write adds the step division, and the first emit of each
// output row adds the two row divisions, all done by one shared bit-serial divider.
// A finished pixel waits in the output register while out_stall_i is high;
// loads are still taken meanwhile, and the next emit holds at its last step.
// Reset clears the counters and the load index and sets all sizes to 256;
// the image RAM is not cleared, so pixels must be loaded before emitting.
module box_filter_image_resampler_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bfir_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bfir_pkg::REG_W-1:0]     cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           mode_i,
  input  logic [bfir_pkg::PIX_W-1:0]     pixel_in_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [bfir_pkg::PIX_W-1:0]     pixel_out_o,
  output logic                           frame_end_o
);
  import bfir_pkg::*;

  localparam int unsigned STATE_W = 4;
  localparam logic [STATE_W-1:0] S_IDLE   = 4'd0;
  localparam logic [STATE_W-1:0] S_STEP   = 4'd1;
  localparam logic [STATE_W-1:0] S_ROWCHK = 4'd2;
  localparam logic [STATE_W-1:0] S_RA     = 4'd3;
  localparam logic [STATE_W-1:0] S_RB     = 4'd4;
  localparam logic [STATE_W-1:0] S_COL    = 4'd5;
  localparam logic [STATE_W-1:0] S_CSUM   = 4'd6;
  localparam logic [STATE_W-1:0] S_RD0    = 4'd7;
  localparam logic [STATE_W-1:0] S_RD1    = 4'd8;
  localparam logic [STATE_W-1:0] S_RD2    = 4'd9;
  localparam logic [STATE_W-1:0] S_RD3    = 4'd10;
  localparam logic [STATE_W-1:0] S_ACC    = 4'd11;
  localparam logic [STATE_W-1:0] S_OUT    = 4'd12;

  logic [STATE_W-1:0] state_q;

  // Configuration
  size_t in_width_q, in_height_q, out_width_q, out_height_q;
  size_t iw, ih, ow, oh;
  logic  settle_q;

  // Counters
  logic [LOAD_W-1:0]  load_idx_q;
  logic [TOTAL_W-1:0] total_q;
  logic [COORD_W-1:0] out_col_q, out_row_q;

  // Emit working registers
  logic [COORD_W-1:0] x_q, y_q;
  logic               fend_q;
  logic               step_ok_q, row_ok_q;
  logic [COORD_W-1:0] row_tag_q;
  logic [STEP_W-1:0]  step_q;
  logic [COORD_W-1:0] ra_q, rb_q;
  logic [BASE_W-1:0]  base_q;
  logic [REG_W-1:0]   ca_q, cb_q;
  logic [TOTAL_W-1:0] rowa_q, rowb_q;
  logic               oob_q;
  logic [ACC_W-1:0]   acc_q [LANES];
  logic [ACC_W-1:0]   acc_next [LANES];

  // Output register
  logic               out_valid_q;
  logic [PIX_W-1:0]   pixel_q;
  logic               frame_end_q;

  // Divider
  logic                 div_start_q;
  logic [DIV_NUM_W-1:0] div_num_q;
  logic [DIV_DEN_W-1:0] div_den_q;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] div_quo;

  // RAM
  logic                  ram_we;
  logic [IMG_ADDR_W-1:0] ram_addr;
  logic [PIX_W-1:0]      ram_rdata;

  logic               in_accept;
  logic               out_free;
  logic [LOAD_W-1:0]  load_eff;
  logic [TOTAL_W-1:0] load_inc;
  logic [LOAD_W-1:0]  load_next;
  logic               last_col, last_row;
  logic [COORD_W-1:0] x_clamp, y_clamp;
  logic [SADDR_W-1:0] rd_addr;
  logic               rd_oob;
  logic [DIV_NUM_W-1:0] row_num_a, row_num_b;
  logic [BASE_W:0]    sum_a, sum_b;

  assign iw = eff_size(in_width_q);
  assign ih = eff_size(in_height_q);
  assign ow = eff_size(out_width_q);
  assign oh = eff_size(out_height_q);

  assign in_stall_o = (state_q != S_IDLE) || settle_q;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Load address with wrap at image end
  assign load_eff  = ({1'b0, load_idx_q} >= total_q) ? '0 : load_idx_q;
  assign load_inc  = {1'b0, load_eff} + TOTAL_W'(1);
  assign load_next = (load_inc >= total_q) ? '0 : load_inc[LOAD_W-1:0];

  // Output position, clamped to the current size
  assign last_col = ({1'b0, out_col_q} + REG_W'(1)) >= ow;
  assign last_row = ({1'b0, out_row_q} + REG_W'(1)) >= oh;
  assign x_clamp  = ({1'b0, out_col_q} >= ow) ? COORD_W'(ow - REG_W'(1)) : out_col_q;
  assign y_clamp  = ({1'b0, out_row_q} >= oh) ? COORD_W'(oh - REG_W'(1)) : out_row_q;

  // Row numerators (4y+1)*ih and (4y+3)*ih
  assign row_num_a = DIV_NUM_W'({y_q, 2'b01} * ih);
  assign row_num_b = DIV_NUM_W'({y_q, 2'b11} * ih);

  // Column sums: quarter and three-quarter step plus x*step
  assign sum_a = (BASE_W+1)'(step_q >> 2) + (BASE_W+1)'(base_q);
  assign sum_b = (BASE_W+1)'(3 * (step_q >> 2)) + (BASE_W+1)'(base_q);

  // Sample address for each read slot
  always_comb begin
    case (state_q)
      S_RD1:   rd_addr = SADDR_W'(rowa_q) + SADDR_W'(cb_q);
      S_RD2:   rd_addr = SADDR_W'(rowb_q) + SADDR_W'(ca_q);
      S_RD3:   rd_addr = SADDR_W'(rowb_q) + SADDR_W'(cb_q);
      default: rd_addr = SADDR_W'(rowa_q) + SADDR_W'(ca_q);
    endcase
  end
  assign rd_oob = rd_addr >= SADDR_W'(IMG_DEPTH);

  assign ram_we   = in_accept && !mode_i && ({1'b0, load_eff} < TOTAL_W'(IMG_DEPTH));
  assign ram_addr = ram_we ? load_eff[IMG_ADDR_W-1:0] : rd_addr[IMG_ADDR_W-1:0];

  // Add the returning sample per lane; samples beyond the store read zero
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      acc_next[l] = acc_q[l] +
                    (oob_q ? '0 : ACC_W'(ram_rdata[l*LANE_W +: LANE_W]));
    end
  end

  bfir_ram #(
    .Width(PIX_W),
    .Depth(IMG_DEPTH)
  ) u_image_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(pixel_in_i),
    .rdata_o(ram_rdata)
  );

  bfir_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start_q),
    .num_i  (div_num_q),
    .den_i  (div_den_q),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      in_width_q   <= size_t'(REG_RESET);
      in_height_q  <= size_t'(REG_RESET);
      out_width_q  <= size_t'(REG_RESET);
      out_height_q <= size_t'(REG_RESET);
      settle_q     <= 1'b0;
      load_idx_q   <= '0;
      out_col_q    <= '0;
      out_row_q    <= '0;
      step_ok_q    <= 1'b0;
      row_ok_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      div_start_q  <= 1'b0;
    end else begin
      settle_q    <= cfg_we_i;
      div_start_q <= 1'b0;

      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_IN_WIDTH:   in_width_q   <= cfg_wdata_i;
          REG_IN_HEIGHT:  in_height_q  <= cfg_wdata_i;
          REG_OUT_WIDTH:  out_width_q  <= cfg_wdata_i;
          REG_OUT_HEIGHT: out_height_q <= cfg_wdata_i;
          default: ;
        endcase
        // Cached step and rows depend on the sizes
        step_ok_q <= 1'b0;
        row_ok_q  <= 1'b0;
      end

      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            if (!mode_i) begin
              load_idx_q <= load_next;
            end else begin
              if (last_col) begin
                out_col_q <= '0;
                out_row_q <= last_row ? '0 : out_row_q + COORD_W'(1);
              end else begin
                out_col_q <= out_col_q + COORD_W'(1);
              end
              if (!step_ok_q) begin
                div_start_q <= 1'b1;
                state_q     <= S_STEP;
              end else begin
                state_q <= S_ROWCHK;
              end
            end
          end
        end
        S_STEP: begin
          if (div_done) begin
            step_ok_q <= 1'b1;
            state_q   <= S_ROWCHK;
          end
        end
        S_ROWCHK: begin
          if (row_ok_q && row_tag_q == y_q) begin
            state_q <= S_COL;
          end else begin
            div_start_q <= 1'b1;
            state_q     <= S_RA;
          end
        end
        S_RA: begin
          if (div_done) begin
            div_start_q <= 1'b1;
            state_q     <= S_RB;
          end
        end
        S_RB: begin
          if (div_done) begin
            row_ok_q <= 1'b1;
            state_q  <= S_COL;
          end
        end
        S_COL:  state_q <= S_CSUM;
        S_CSUM: state_q <= S_RD0;
        S_RD0:  state_q <= S_RD1;
        S_RD1:  state_q <= S_RD2;
        S_RD2:  state_q <= S_RD3;
        S_RD3:  state_q <= S_ACC;
        S_ACC:  state_q <= S_OUT;
        S_OUT: begin
          // Hold until the output register can take the pixel
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    total_q <= TOTAL_W'(iw * ih);
    oob_q   <= rd_oob;

    case (state_q)
      S_IDLE: begin
        x_q       <= x_clamp;
        y_q       <= y_clamp;
        fend_q    <= last_col && last_row;
        div_num_q <= DIV_NUM_W'({iw, FRAC_W'(0)});
        div_den_q <= DIV_DEN_W'(ow);
      end
      S_STEP: begin
        if (div_done) begin
          step_q <= div_quo;
        end
      end
      S_ROWCHK: begin
        div_num_q <= row_num_a;
        div_den_q <= DIV_DEN_W'({oh, 2'b00});
      end
      S_RA: begin
        if (div_done) begin
          ra_q      <= div_quo[COORD_W-1:0];
          div_num_q <= row_num_b;
        end
      end
      S_RB: begin
        if (div_done) begin
          rb_q      <= div_quo[COORD_W-1:0];
          row_tag_q <= y_q;
        end
      end
      S_COL: begin
        base_q <= BASE_W'(x_q * step_q);
      end
      S_CSUM: begin
        ca_q   <= sum_a[FRAC_W +: REG_W];
        cb_q   <= sum_b[FRAC_W +: REG_W];
        rowa_q <= TOTAL_W'(ra_q * iw);
        rowb_q <= TOTAL_W'(rb_q * iw);
      end
      S_RD0: begin
        for (int l = 0; l < LANES; l++) begin
          acc_q[l] <= '0;
        end
      end
      S_RD1, S_RD2, S_RD3, S_ACC: begin
        acc_q <= acc_next;
      end
      S_OUT: begin
        if (out_free) begin
          for (int l = 0; l < LANES; l++) begin
            pixel_q[l*LANE_W +: LANE_W] <= acc_q[l][ACC_W-1:2];
          end
          frame_end_q <= fend_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = pixel_q;
  assign frame_end_o = frame_end_q;

endmodule
